[rtl/core/hcbd_pkg.sv]
package hcbd_pkg;

	localparam int unsigned COUNT_WIDTH = 32;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	typedef enum logic [2:0] {
		PH_SIZE    = 3'd0,
		PH_EXT     = 3'd1,
		PH_DATA    = 3'd2,
		PH_DATA_CR = 3'd3,
		PH_DATA_LF = 3'd4,
		PH_DONE    = 3'd5
	} phase_t;

	typedef struct packed {
		phase_t                 phase;
		logic [COUNT_WIDTH-1:0] count;
		logic                   digit_seen;
		logic                   error;
	} dec_state_t;

	typedef struct packed {
		logic       is_hex;
		logic [3:0] value;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		h.is_hex = 1'b1;
		h.value  = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.value = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			h.value = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h.value = 4'(c - 8'h37);
		end else begin
			h.is_hex = 1'b0;
		end
		return h;
	endfunction

endpackage

[rtl/core/hcbd_step.sv]
module hcbd_step (
	input  hcbd_pkg::dec_state_t cur,
	input  logic [7:0]           c,
	output hcbd_pkg::dec_state_t nxt,
	output logic                 pay_valid,
	output logic [7:0]           pay_byte
);

	// Fresh size line state, used after a chunk's data delimiter or where it is missing
	function automatic hcbd_pkg::dec_state_t fresh_line(input hcbd_pkg::dec_state_t s);
		hcbd_pkg::dec_state_t r;
		r            = s;
		r.phase      = hcbd_pkg::PH_SIZE;
		r.count      = '0;
		r.digit_seen = 1'b0;
		return r;
	endfunction

	function automatic hcbd_pkg::dec_state_t end_line(input hcbd_pkg::dec_state_t s);
		hcbd_pkg::dec_state_t r;
		r       = s;
		r.phase = (s.count == '0) ? hcbd_pkg::PH_DONE : hcbd_pkg::PH_DATA;
		return r;
	endfunction

	function automatic hcbd_pkg::dec_state_t size_byte(input hcbd_pkg::dec_state_t s,
			input logic [7:0] b);
		hcbd_pkg::dec_state_t r;
		hcbd_pkg::hex_t       h;
		r = s;
		h = hcbd_pkg::hex_decode(b);
		if (h.is_hex) begin
			// another digit would push bits out of the top nibble
			if (s.count[hcbd_pkg::COUNT_WIDTH-1 -: 4] != 4'd0) begin
				r.error = 1'b1;
			end else begin
				r.count      = {s.count[hcbd_pkg::COUNT_WIDTH-5:0], h.value};
				r.digit_seen = 1'b1;
			end
		end else if (!s.digit_seen) begin
			r.error = 1'b1;
		end else if (b == hcbd_pkg::CH_LF) begin
			r = end_line(s);
		end else begin
			r.phase = hcbd_pkg::PH_EXT;
		end
		return r;
	endfunction

	logic [hcbd_pkg::COUNT_WIDTH-1:0] count_dec;

	assign count_dec = cur.count - hcbd_pkg::COUNT_WIDTH'(1);

	always_comb begin
		nxt       = cur;
		pay_valid = 1'b0;
		pay_byte  = 8'h00;
		if (!cur.error) begin
			case (cur.phase)
				hcbd_pkg::PH_SIZE: begin
					nxt = size_byte(cur, c);
				end
				hcbd_pkg::PH_EXT: begin
					if (c == hcbd_pkg::CH_LF) begin
						nxt = end_line(cur);
					end
				end
				hcbd_pkg::PH_DATA: begin
					pay_valid = 1'b1;
					pay_byte  = c;
					nxt.count = count_dec;
					if (count_dec == '0) begin
						nxt.phase = hcbd_pkg::PH_DATA_CR;
					end
				end
				hcbd_pkg::PH_DATA_CR: begin
					if (c == hcbd_pkg::CH_CR) begin
						nxt.phase = hcbd_pkg::PH_DATA_LF;
					end else if (c == hcbd_pkg::CH_LF) begin
						nxt = fresh_line(cur);
					end else begin
						nxt = size_byte(fresh_line(cur), c);
					end
				end
				hcbd_pkg::PH_DATA_LF: begin
					if (c == hcbd_pkg::CH_LF) begin
						nxt = fresh_line(cur);
					end else begin
						nxt = size_byte(fresh_line(cur), c);
					end
				end
				hcbd_pkg::PH_DONE: begin
					nxt = cur;
				end
				default: begin
					nxt = size_byte(fresh_line(cur), c);
				end
			endcase
		end
	end

endmodule

[rtl/core/http_chunked_body_decoder_top.sv]
// HTTP/1.1 chunked body decoder.
// Input channel: body_valid/body_ready carry one raw body byte per beat.
// Output channel: result_valid/result_ready carry exactly one result per input
// beat: payload_valid/payload_byte (payload_byte is zero for non-payload
// bytes), body_done once the zero-size chunk line has ended, and the sticky
// format_error flag.
// The result of an input beat is registered and appears in the cycle after the beat is taken.
// Throughput: one byte per cycle while results are taken; the parser state and the
// result register update in the same cycle, so the size shift-add/compare and the
// data down-counter are the per-cycle path.
// A new byte is taken while a result waits, as long as the result is taken
// in that same cycle; if result_ready stays low the held result blocks the
// input and body_ready drops until the result is taken.
// Reset (arst_n low) returns the parser to the start of a size line and
// clears the done and error flags; no result is pending afterwards.
module http_chunked_body_decoder_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       body_valid,
	output logic       body_ready,
	input  logic [7:0] body_byte,
	output logic       result_valid,
	input  logic       result_ready,
	output logic       payload_valid,
	output logic [7:0] payload_byte,
	output logic       body_done,
	output logic       format_error
);

	hcbd_pkg::dec_state_t state_q;
	hcbd_pkg::dec_state_t state_nxt;
	logic                 pay_valid_nxt;
	logic [7:0]           pay_byte_nxt;
	logic                 out_valid_q;
	logic                 pay_valid_q;
	logic [7:0]           pay_byte_q;
	logic                 done_q;
	logic                 err_q;
	logic                 in_beat;

	assign body_ready = !out_valid_q || result_ready;
	assign in_beat    = body_valid && body_ready;

	hcbd_step u_step (
		.cur       (state_q),
		.c         (body_byte),
		.nxt       (state_nxt),
		.pay_valid (pay_valid_nxt),
		.pay_byte  (pay_byte_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase      <= hcbd_pkg::PH_SIZE;
			state_q.count      <= '0;
			state_q.digit_seen <= 1'b0;
			state_q.error      <= 1'b0;
			out_valid_q        <= 1'b0;
			pay_valid_q        <= 1'b0;
			done_q             <= 1'b0;
			err_q              <= 1'b0;
		end else begin
			if (in_beat) begin
				state_q     <= state_nxt;
				out_valid_q <= 1'b1;
				pay_valid_q <= pay_valid_nxt;
				done_q      <= (state_nxt.phase == hcbd_pkg::PH_DONE) && !state_nxt.error;
				err_q       <= state_nxt.error;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			pay_byte_q <= pay_byte_nxt;
		end
	end

	assign result_valid  = out_valid_q;
	assign payload_valid = pay_valid_q;
	assign payload_byte  = pay_byte_q;
	assign body_done     = done_q;
	assign format_error  = err_q;

endmodule

[rtl/core/hcbd_checker.sv]
module hcbd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       body_ready,
	input logic       result_valid,
	input logic       result_ready,
	input logic       payload_valid,
	input logic [7:0] payload_byte,
	input logic       body_done,
	input logic       format_error
);

	// error and done never clear once a beat has shown them
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(format_error) |-> format_error)
		else $error("format_error cleared");

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(body_done) |-> (body_done || format_error))
		else $error("body_done cleared");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && payload_valid) |-> (!format_error && !body_done))
		else $error("payload beat after end or error");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=> (result_valid && $stable(payload_byte)))
		else $error("stalled result dropped or changed");

	a_no_take_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |-> !body_ready)
		else $error("input taken while result stalled");

endmodule

bind http_chunked_body_decoder_top hcbd_checker u_hcbd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.body_ready    (body_ready),
	.result_valid  (result_valid),
	.result_ready  (result_ready),
	.payload_valid (payload_valid),
	.payload_byte  (payload_byte),
	.body_done     (body_done),
	.format_error  (format_error)
);

[test/tb.sv]
module tb;

	typedef struct packed {
		logic       pay_valid;
		logic [7:0] pay_byte;
		logic       done;
		logic       err;
	} dec_out_t;

	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam int BODY_ITEMS  = 1900;
	localparam int PAUSE_EVERY = 500;
	localparam int IDLE_LIMIT  = 2000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       body_valid = 1'b0;
	logic [7:0] body_byte = 8'h00;
	logic       result_ready = 1'b0;
	logic       body_ready;
	logic       result_valid;
	logic       payload_valid;
	logic [7:0] payload_byte;
	logic       body_done;
	logic       format_error;

	http_chunked_body_decoder_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.body_valid   (body_valid),
		.body_ready   (body_ready),
		.body_byte    (body_byte),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.payload_valid(payload_valid),
		.payload_byte (payload_byte),
		.body_done    (body_done),
		.format_error (format_error)
	);

	always #2 clk = ~clk;

	// decoder shadow state
	hcbd_pkg::phase_t                 dec_phase;
	logic [hcbd_pkg::COUNT_WIDTH-1:0] dec_left;
	logic                             dec_digits;
	logic                             dec_err;

	logic [7:0] body_q[$];
	dec_out_t   pending[$];
	int         errors = 0;

	function automatic logic [4:0] nibble_of(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39)
			return {1'b1, 4'(c - 8'h30)};
		if (c >= 8'h61 && c <= 8'h66)
			return {1'b1, 4'(c - 8'h61 + 8'd10)};
		if (c >= 8'h41 && c <= 8'h46)
			return {1'b1, 4'(c - 8'h41 + 8'd10)};
		return 5'd0;
	endfunction

	task automatic restart_size_line();
		dec_phase  = hcbd_pkg::PH_SIZE;
		dec_left   = '0;
		dec_digits = 1'b0;
	endtask

	task automatic close_size_line();
		dec_phase = (dec_left == 0) ? hcbd_pkg::PH_DONE : hcbd_pkg::PH_DATA;
	endtask

	task automatic size_char(input logic [7:0] c);
		logic [4:0] h;
		h = nibble_of(c);
		if (h[4]) begin
			if (dec_left[hcbd_pkg::COUNT_WIDTH-1 -: 4] != 0) begin
				dec_err = 1'b1;
			end else begin
				dec_left   = {dec_left[hcbd_pkg::COUNT_WIDTH-5:0], h[3:0]};
				dec_digits = 1'b1;
			end
		end else if (!dec_digits) begin
			dec_err = 1'b1;
		end else if (c == hcbd_pkg::CH_LF) begin
			close_size_line();
		end else begin
			dec_phase = hcbd_pkg::PH_EXT;
		end
	endtask

	task automatic decode_byte(input logic [7:0] c, output dec_out_t r);
		r = '0;
		if (!dec_err) begin
			case (dec_phase)
				hcbd_pkg::PH_SIZE: size_char(c);
				hcbd_pkg::PH_EXT: begin
					if (c == hcbd_pkg::CH_LF)
						close_size_line();
				end
				hcbd_pkg::PH_DATA: begin
					r.pay_valid = 1'b1;
					r.pay_byte  = c;
					dec_left    = dec_left - 1'b1;
					if (dec_left == 0)
						dec_phase = hcbd_pkg::PH_DATA_CR;
				end
				hcbd_pkg::PH_DATA_CR: begin
					if (c == hcbd_pkg::CH_CR) begin
						dec_phase = hcbd_pkg::PH_DATA_LF;
					end else begin
						restart_size_line();
						if (c != hcbd_pkg::CH_LF)
							size_char(c);
					end
				end
				hcbd_pkg::PH_DATA_LF: begin
					restart_size_line();
					if (c != hcbd_pkg::CH_LF)
						size_char(c);
				end
				hcbd_pkg::PH_DONE: ;
				default: begin
					restart_size_line();
					size_char(c);
				end
			endcase
		end
		r.done = (dec_phase == hcbd_pkg::PH_DONE) && !dec_err;
		r.err  = dec_err;
	endtask

	// stimulus builders
	task automatic put(input logic [7:0] c);
		body_q.push_back(c);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
		if (v < 10)
			return 8'h30 + v;
		return (upper ? 8'h41 : 8'h61) + v - 8'd10;
	endfunction

	task automatic put_size(input int unsigned n, input int unsigned lead);
		int nd;
		nd = 1;
		while (nd < 8 && (n >> (4 * nd)) != 0)
			nd++;
		repeat (lead) put(CH_ZERO);
		for (int i = nd - 1; i >= 0; i--)
			put(hex_char(4'((n >> (4 * i)) & 15), 1'($urandom_range(1, 0))));
	endtask

	task automatic put_line_end();
		logic [7:0] c;
		if ($urandom_range(3, 0) == 0) begin
			case ($urandom_range(2, 0))
				0: put(CH_SEMI);
				1: put(CH_SP);
				default: put(CH_TAB);
			endcase
			repeat ($urandom_range(6, 0)) begin
				c = 8'($urandom_range(255, 0));
				put(c == hcbd_pkg::CH_LF ? CH_SEMI : c);
			end
		end
		if ($urandom_range(3, 0) != 0)
			put(hcbd_pkg::CH_CR);
		put(hcbd_pkg::CH_LF);
	endtask

	task automatic put_data(input int unsigned n);
		repeat (n) begin
			if ($urandom_range(7, 0) == 0)
				put($urandom_range(1, 0) ? hcbd_pkg::CH_CR : hcbd_pkg::CH_LF);
			else
				put(8'($urandom_range(255, 0)));
		end
	endtask

	function automatic int unsigned chunk_len();
		int unsigned r;
		r = $urandom_range(19, 0);
		if (r < 14)
			return $urandom_range(16, 1);
		if (r < 19)
			return $urandom_range(64, 17);
		return $urandom_range(600, 65);
	endfunction

	// mostly short gaps, a few long ones, and now and then a stretch with none
	function automatic int unsigned pick_gap(inout int unsigned calm);
		int unsigned r;
		if (calm != 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(99, 0) == 0)
			calm = $urandom_range(150, 40);
		r = $urandom_range(9, 0);
		if (r < 6)
			return 0;
		if (r < 9)
			return $urandom_range(3, 1);
		return $urandom_range(30, 5);
	endfunction

	// sender
	int unsigned send_gap, send_calm, sent;
	bit          hold;
	logic        nv;
	logic [7:0]  nb;
	dec_out_t    predicted;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_valid <= 1'b0;
			body_byte  <= 8'h00;
			send_gap  = 0;
			send_calm = 0;
			sent      = 0;
			hold      = 1'b0;
			restart_size_line();
			dec_err = 1'b0;
		end else begin
			nv = body_valid;
			nb = body_byte;
			if (body_valid && body_ready) begin
				decode_byte(body_byte, predicted);
				pending.push_back(predicted);
				void'(body_q.pop_front());
				sent++;
				if (sent % PAUSE_EVERY == 0)
					hold = 1'b1;
				send_gap = pick_gap(send_calm);
				nv = 1'b0;
			end
			if (!nv) begin
				if (send_gap != 0)
					send_gap--;
				else if (hold)
					hold = (pending.size() != 0);
				else if (body_q.size() != 0) begin
					nv = 1'b1;
					nb = body_q[0];
				end
			end
			body_valid <= nv;
			body_byte  <= nb;
		end
	end

	// receiver
	int unsigned take_gap, take_calm;
	dec_out_t    want, got;

	task automatic mismatch(input string what, input int unsigned exp_v, input int unsigned act_v);
		errors++;
		$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, exp_v, act_v);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			take_gap  = 0;
			take_calm = 0;
		end else begin
			if (result_valid && result_ready) begin
				got = {payload_valid, payload_byte, body_done, format_error};
				if (pending.size() == 0) begin
					errors++;
					$display("%0t: result beat with nothing outstanding, actual 0x%0h",
						$time, got);
				end else begin
					want = pending.pop_front();
					if (got.pay_valid !== want.pay_valid)
						mismatch("payload_valid", want.pay_valid, got.pay_valid);
					if (got.pay_byte !== want.pay_byte)
						mismatch("payload_byte", want.pay_byte, got.pay_byte);
					if (got.done !== want.done)
						mismatch("body_done", want.done, got.done);
					if (got.err !== want.err)
						mismatch("format_error", want.err, got.err);
				end
			end
			if (take_gap != 0) begin
				take_gap--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
				take_gap = pick_gap(take_calm);
			end
		end
	end

	int unsigned idle_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (body_valid && body_ready) || (result_valid && result_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("http_chunked_body_decoder_top verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int unsigned n, r;
		logic [7:0]  c;

		// 3-byte chunk carrying 00, FF and a CR
		put(8'h33); put(hcbd_pkg::CH_CR); put(hcbd_pkg::CH_LF);
		put(8'h00); put(8'hFF); put(hcbd_pkg::CH_CR);
		put(hcbd_pkg::CH_CR); put(hcbd_pkg::CH_LF);
		// a leading zero, extension, bare LF everywhere, LF inside the data
		put(CH_ZERO); put(8'h32); put(CH_SEMI); put(8'h78); put(hcbd_pkg::CH_LF);
		put(hcbd_pkg::CH_LF); put(8'h80);
		put(hcbd_pkg::CH_LF);
		// delimiter missing altogether
		put(8'h31); put(hcbd_pkg::CH_CR); put(hcbd_pkg::CH_LF); put(8'h7F);
		// CR after the data with no LF behind it
		put(8'h31); put(hcbd_pkg::CH_LF); put(8'h41); put(hcbd_pkg::CH_CR);

		while (body_q.size() < BODY_ITEMS) begin
			n = chunk_len();
			put_size(n, ($urandom_range(7, 0) == 0) ? $urandom_range(4, 1) : 0);
			put_line_end();
			put_data(n);
			r = $urandom_range(9, 0);
			if (r < 6) begin
				put(hcbd_pkg::CH_CR);
				put(hcbd_pkg::CH_LF);
			end else if (r < 8) begin
				put(hcbd_pkg::CH_LF);
			end else if (r == 8) begin
				put(hcbd_pkg::CH_CR);
			end
		end

		// the body ends one of three ways; everything after is ignored
		case ($urandom_range(2, 0))
			0: begin
				put_size(0, $urandom_range(2, 0));
				put_line_end();
			end
			1: begin
				put(hex_char(4'($urandom_range(15, 1)), 1'($urandom_range(1, 0))));
				repeat (8)
					put(hex_char(4'($urandom_range(15, 0)), 1'($urandom_range(1, 0))));
			end
			default: begin
				if ($urandom_range(1, 0)) begin
					case ($urandom_range(2, 0))
						0: c = hcbd_pkg::CH_CR;
						1: c = hcbd_pkg::CH_LF;
						default: c = CH_SP;
					endcase
				end else begin
					do
						c = 8'($urandom_range(255, 0));
					while (nibble_of(c) != 0);
				end
				put(c);
			end
		endcase
		repeat ($urandom_range(30, 10))
			put(8'($urandom_range(255, 0)));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (body_q.size() != 0 || pending.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (errors == 0)
			$display("http_chunked_body_decoder_top verification clean");
		else
			$display("http_chunked_body_decoder_top verification failed");
		$finish;
	end

endmodule

[sim.f]
rtl/core/hcbd_pkg.sv
rtl/core/hcbd_step.sv
rtl/core/http_chunked_body_decoder_top.sv
rtl/core/hcbd_checker.sv
test/tb.sv
